>>> rtl/core/leb_pkg.sv
// Shared types and codes of the unsigned LEB128 varint codec.
// No dependencies; every module of the codec imports this package.
`default_nettype none

package leb_pkg;

    localparam int unsigned ValueW = 64;
    localparam int unsigned GroupW = 7;
    localparam int unsigned LenW   = 4;

    // Request codes on the input word.
    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    // Result kinds on the output word.
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Longest legal sequence in each mode.
    localparam logic [LenW-1:0] LIMIT_NARROW = 4'd5;
    localparam logic [LenW-1:0] LIMIT_WIDE   = 4'd10;

    typedef enum logic {
        ST_IDLE,
        ST_ENC
    } t_state;

    // Control from the sequencer to the encode shifter.
    typedef struct packed {
        logic load;
        logic step;
    } t_enc_ctl;

    // Byte produced by the encode shifter.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_enc_out;

    // Result of one decoded byte.
    typedef struct packed {
        logic                valid;
        logic [1:0]          kind;
        logic [ValueW-1:0]   value;
        logic [LenW-1:0]     length;
    } t_dec_res;

endpackage

`default_nettype wire

>>> rtl/core/leb_enc_shift.sv
// Encode shifter: holds the value being encoded and strips one 7-bit group per step.
// Depends on leb_pkg.
`default_nettype none

module leb_enc_shift
    import leb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_enc_ctl          i_ctl,
    input  wire logic [ValueW-1:0] i_value,
    output t_enc_out               o_out
);

    logic [ValueW-1:0] r_val;
    logic [ValueW-1:0] n_val;
    logic [ValueW-1:0] w_rest;

    // The shared unit: a fixed right shift by one group.
    assign w_rest = r_val >> GroupW;

    always_comb begin
        o_out.last = (w_rest == '0);
        o_out.data = {~o_out.last, r_val[GroupW-1:0]};
        n_val      = r_val;
        if (i_ctl.load) begin
            n_val = i_value;
        end else if (i_ctl.step) begin
            n_val = w_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire

>>> rtl/core/leb_dec_acc.sv
// Decode accumulator: places each 7-bit group at its slot and counts bytes.
// Depends on leb_pkg.
`default_nettype none

module leb_dec_acc
    import leb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_strobe,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_wide,
    output t_dec_res        o_res
);

    localparam int unsigned Slots = 10;
    localparam int unsigned ExtW  = Slots * GroupW;

    logic [ValueW-1:0] r_acc;
    logic [ValueW-1:0] n_acc;
    logic [LenW-1:0]   r_cnt;
    logic [LenW-1:0]   n_cnt;
    logic [ExtW-1:0]   w_ext;
    logic [ValueW-1:0] w_merged;
    logic [LenW-1:0]   w_pos;
    logic [LenW-1:0]   w_limit;

    always_comb begin
        w_ext = '0;
        for (int k = 0; k < Slots; k++) begin
            if (r_cnt == LenW'(k)) begin
                w_ext[k*GroupW +: GroupW] = i_byte[GroupW-1:0];
            end
        end
        // Group bits that fall above bit 63 are dropped.
        w_merged = r_acc | w_ext[ValueW-1:0];
        w_pos    = r_cnt + 1'b1;
        w_limit  = i_wide ? LIMIT_WIDE : LIMIT_NARROW;

        o_res  = '0;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        if (i_strobe) begin
            n_acc = w_merged;
            n_cnt = w_pos;
            if (!i_byte[7]) begin
                o_res.valid  = 1'b1;
                o_res.kind   = KIND_VALUE;
                o_res.value  = i_wide ? w_merged : {32'd0, w_merged[31:0]};
                o_res.length = w_pos;
                n_acc        = '0;
                n_cnt        = '0;
            end else if (w_pos >= w_limit) begin
                o_res.valid = 1'b1;
                o_res.kind  = KIND_ERROR;
                n_acc       = '0;
                n_cnt       = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/leb128_varint_codec.sv
// Top level of the unsigned LEB128 varint codec: sequencer, mode register, output register.
// Depends on leb_pkg, leb_enc_shift and leb_dec_acc.
`default_nettype none

// Channel   Handshake                    Payload
// input     i_in_valid / o_in_ready      i_req_type, i_plain_value, i_coded_byte
// output    o_out_valid / i_out_ready    o_result_kind, o_out_byte, o_last_byte,
//                                        o_decoded_value, o_byte_length
// config    i_cfg_we                     i_cfg_wdata (wide mode)
//
// A decode word is taken by the decoder; the block is ready again on the next cycle
// as long as the output register is empty or being drained.
// An encode word first loads the shifter, then emits one byte per step, paced by the
// output register, which holds one word; no new word is taken until the last byte.
// Reset is synchronous and active low; it clears the decoder, the sequencer,
// the output valid flag, and sets wide mode.
// A stalled output simply holds the shifter until the byte is taken.

module leb128_varint_codec
    import leb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata,

    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_req_type,
    input  wire logic [ValueW-1:0] i_plain_value,
    input  wire logic [7:0]        i_coded_byte,

    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [1:0]             o_result_kind,
    output logic [7:0]             o_out_byte,
    output logic                   o_last_byte,
    output logic [ValueW-1:0]      o_decoded_value,
    output logic [LenW-1:0]        o_byte_length
);

    t_state            r_state;
    t_state            n_state;
    logic              r_wide;

    logic              r_out_valid;
    logic              n_out_valid;
    logic [1:0]        r_kind;
    logic [1:0]        n_kind;
    logic [7:0]        r_byte;
    logic [7:0]        n_byte;
    logic              r_last;
    logic              n_last;
    logic [ValueW-1:0] r_value;
    logic [ValueW-1:0] n_value;
    logic [LenW-1:0]   r_len;
    logic [LenW-1:0]   n_len;

    logic              w_out_free;
    logic              w_accept;
    logic              w_dec_strobe;
    logic [ValueW-1:0] w_enc_value;
    t_enc_ctl          w_enc_ctl;
    t_enc_out          w_enc_out;
    t_dec_res          w_dec_res;

    // The output register can take a new word when it is empty or being read.
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == ST_IDLE) && w_out_free;
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_dec_strobe = w_accept && (i_req_type == REQ_DECODE);

    // Narrow mode ignores the upper half of the value.
    assign w_enc_value = r_wide ? i_plain_value : {32'd0, i_plain_value[31:0]};

    always_comb begin
        w_enc_ctl.load = w_accept && (i_req_type == REQ_ENCODE);
        w_enc_ctl.step = (r_state == ST_ENC) && w_out_free;
    end

    leb_enc_shift u_enc (
        .i_clk   (i_clk),
        .i_ctl   (w_enc_ctl),
        .i_value (w_enc_value),
        .o_out   (w_enc_out)
    );

    leb_dec_acc u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_strobe (w_dec_strobe),
        .i_byte   (i_coded_byte),
        .i_wide   (r_wide),
        .o_res    (w_dec_res)
    );

    // Sequencer and output register loading.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_byte      = r_byte;
        n_last      = r_last;
        n_value     = r_value;
        n_len       = r_len;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_enc_ctl.load) begin
                    n_state = ST_ENC;
                end else if (w_dec_res.valid) begin
                    n_out_valid = 1'b1;
                    n_kind      = w_dec_res.kind;
                    n_byte      = '0;
                    n_last      = 1'b0;
                    n_value     = w_dec_res.value;
                    n_len       = w_dec_res.length;
                end
            end
            ST_ENC: begin
                if (w_enc_ctl.step) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_BYTE;
                    n_byte      = w_enc_out.data;
                    n_last      = w_enc_out.last;
                    n_value     = '0;
                    n_len       = '0;
                    if (w_enc_out.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wide      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_wide <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_byte  <= n_byte;
        r_last  <= n_last;
        r_value <= n_value;
        r_len   <= n_len;
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_kind;
    assign o_out_byte      = r_byte;
    assign o_last_byte     = r_last;
    assign o_decoded_value = r_value;
    assign o_byte_length   = r_len;

endmodule

`default_nettype wire
